### sv/mlt_pkg.sv
// Package for the adaptive mean threshold block.
// Holds register codes, reset values and fixed field widths; no dependencies.
package mlt_pkg;

    localparam int PIX_W      = 8;
    localparam int OFFSET_W   = 8;
    localparam int HALF_W     = 3;
    localparam int FWIDTH_W   = 11;
    localparam int FHEIGHT_W  = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_OUT    = 8;
    localparam int NOUT_W     = 4;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_C_OFFSET     = 2'd0;
    localparam logic [1:0] REG_WINDOW_HALF  = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam logic [OFFSET_W-1:0]  RST_C_OFFSET     = 8'd5;
    localparam logic [HALF_W-1:0]    RST_WINDOW_HALF  = 3'd1;
    localparam logic [FWIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FHEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd480;

endpackage

### sv/mlt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by the threshold sequencer for the window mean.
module mlt_div #(
    parameter int DW = 16,
    parameter int VW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo, n_quo;
    logic [VW:0]   r_rem, n_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [VW:0]   w_shift;
    logic [VW:0]   w_diff;

    always_comb begin
        w_shift = {r_rem[VW-1:0], r_quo[DW-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = CW'(DW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_dvs}) begin
                n_rem = w_diff;
                n_quo = {r_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### sv/mlt_linestore.sv
// Ring line store: one write port and one registered read port.
// Addressed by {ring row, column}; no dependencies.
module mlt_linestore #(
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mean_local_threshold.sv
// Adaptive mean threshold over a raster stream of 8-bit grey pixels.
// Input channel (i_valid/o_ready) takes one word per pixel, or a drain word
// (i_mode high) that only flushes pending results. Output channel
// (o_valid/i_ready) gives one word per result: the object bit, a flag on the
// last result caused by an input word, and a flag on the frame's final pixel.
// Registers sit behind an APB-style port: c_offset, window_half, frame_width,
// frame_height at byte addresses 0, 4, 8 and 12; write only while idle.
// After an input word is accepted the block is busy until all its results
// (at most eight) are computed. For each result the sequencer reads the centre
// pixel and then every cell of its window through the line store's single
// read port and divides the window sum by the cell count in the bit-serial
// divider. A word that releases no result goes straight back to idle.
// A finished result waits in the output register while the next is computed;
// if the receiver stalls, the sequencer holds before loading the next one.
// Reset clears positions and restores the register defaults; the line store
// is not cleared and needs no clearing pass.
module mean_local_threshold #(
    parameter int MAX_HALF  = 7,
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_object_bit,
    output logic        o_last_in_run,
    output logic        o_frame_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mlt_pkg::APB_AW-1:0] paddr,
    input  logic [mlt_pkg::APB_DW-1:0] pwdata,
    output logic [mlt_pkg::APB_DW-1:0] prdata,
    output logic        pready
);

    localparam int RING      = 2 * MAX_HALF + 1;
    localparam int RW        = $clog2(RING);
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int CXW       = CW + 2;
    localparam int HW        = $clog2(MAX_HALF + 1);
    localparam int CELLS_MAX = RING * RING;
    localparam int CNT_W     = $clog2(CELLS_MAX + 1);
    localparam int SUM_W     = $clog2(CELLS_MAX * 255 + 1);
    localparam int AW        = RW + CW;
    localparam int ROW_W     = mlt_pkg::ROW_W;
    localparam int RXW       = mlt_pkg::FHEIGHT_W;
    localparam int CMP_W     = SUM_W + 10;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NEXT = 3'd1;
    localparam logic [2:0] ST_CRD  = 3'd2;
    localparam logic [2:0] ST_CACC = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_DIVS = 3'd6;
    localparam logic [2:0] ST_DIVW = 3'd7;

    // Configuration registers.
    logic [mlt_pkg::OFFSET_W-1:0]  r_c_offset;
    logic [mlt_pkg::HALF_W-1:0]    r_window_half;
    logic [mlt_pkg::FWIDTH_W-1:0]  r_frame_width;
    logic [mlt_pkg::FHEIGHT_W-1:0] r_frame_height;
    logic                          w_cfg_we;

    // Control state.
    logic [2:0]                  r_state, n_state;
    logic [ROW_W-1:0]            r_in_row, n_in_row, r_out_row, n_out_row;
    logic [RW-1:0]               r_in_ring, n_in_ring, r_out_ring, n_out_ring;
    logic [CW-1:0]               r_in_col, n_in_col, r_out_col, n_out_col;
    logic                        r_in_done, n_in_done;
    logic [mlt_pkg::NOUT_W-1:0]  r_n, n_n;
    logic                        r_have, n_have;
    logic                        r_ovalid, n_ovalid;

    // Window work registers.
    logic [ROW_W-1:0] r_r, n_r, r_r1, n_r1;
    logic [RW-1:0]    r_ring, n_ring;
    logic [CW-1:0]    r_c, n_c, r_c0, n_c0, r_c1, n_c1;
    logic             r_empty, n_empty;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_pix, n_pix;
    logic             r_obj, n_obj, r_fd, n_fd;
    logic             r_oobj, n_oobj, r_olast, n_olast, r_ofd, n_ofd;

    // Effective sizes and window bounds.
    logic [CXW-1:0]   w_w, w_wm1, w_nc, w_c0x, w_c1x;
    logic [RXW-1:0]   w_hgt, w_hm1, w_nr, w_r0x, w_r1x;
    logic [HW-1:0]    w_h;
    logic [RW:0]      w_ring0;
    logic             w_res_ok, w_avail, w_accept;
    logic [CMP_W-1:0] w_lhs, w_mean;
    logic [AW-1:0]    w_raddr;
    logic [7:0]       w_rdata;
    logic             w_div_start, w_div_done;
    logic [SUM_W-1:0] w_quo;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_offset     <= mlt_pkg::RST_C_OFFSET;
            r_window_half  <= mlt_pkg::RST_WINDOW_HALF;
            r_frame_width  <= mlt_pkg::RST_FRAME_WIDTH;
            r_frame_height <= mlt_pkg::RST_FRAME_HEIGHT;
        end else if (w_cfg_we) begin
            case (paddr[3:2])
                mlt_pkg::REG_C_OFFSET:     r_c_offset     <= pwdata[7:0];
                mlt_pkg::REG_WINDOW_HALF:  r_window_half  <= pwdata[2:0];
                mlt_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[10:0];
                mlt_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mlt_pkg::REG_C_OFFSET:     prdata = {24'd0, r_c_offset};
            mlt_pkg::REG_WINDOW_HALF:  prdata = {29'd0, r_window_half};
            mlt_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, r_frame_width};
            mlt_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, r_frame_height};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- effective sizes ----------------
    always_comb begin
        if (r_frame_width == '0) begin
            w_w = CXW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_w = CXW'(MAX_WIDTH);
        end else begin
            w_w = CXW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            w_hgt = RXW'(1);
        end else if (32'(r_frame_height) > 32'(mlt_pkg::MAX_HEIGHT)) begin
            w_hgt = RXW'(mlt_pkg::MAX_HEIGHT);
        end else begin
            w_hgt = r_frame_height;
        end
        if (32'(r_window_half) > 32'(MAX_HALF)) begin
            w_h = HW'(MAX_HALF);
        end else begin
            w_h = HW'(r_window_half);
        end
        w_wm1 = w_w - 1'b1;
        w_hm1 = w_hgt - 1'b1;
    end

    // A result is ready once the bottom-right cell of its window has arrived.
    always_comb begin
        w_nr = RXW'(r_out_row) + RXW'(w_h);
        if (w_nr > w_hm1) begin
            w_nr = w_hm1;
        end
        w_nc = CXW'(r_out_col) + CXW'(w_h);
        if (w_nc > w_wm1) begin
            w_nc = w_wm1;
        end
        w_res_ok = r_in_done || (w_nr < RXW'(r_in_row))
                   || ((w_nr == RXW'(r_in_row)) && (w_nc < CXW'(r_in_col)));
        w_avail  = (r_n < mlt_pkg::NOUT_W'(mlt_pkg::MAX_OUT)) && w_res_ok;

        w_r0x = (RXW'(r_out_row) >= RXW'(w_h)) ? RXW'(r_out_row) - RXW'(w_h) : '0;
        w_r1x = w_nr;
        w_c0x = (CXW'(r_out_col) >= CXW'(w_h)) ? CXW'(r_out_col) - CXW'(w_h) : '0;
        w_c1x = w_nc;
        if (RXW'(r_out_row) >= RXW'(w_h)) begin
            if ((RW + 1)'(r_out_ring) >= (RW + 1)'(w_h)) begin
                w_ring0 = (RW + 1)'(r_out_ring) - (RW + 1)'(w_h);
            end else begin
                w_ring0 = (RW + 1)'(r_out_ring) + (RW + 1)'(RING) - (RW + 1)'(w_h);
            end
        end else begin
            w_ring0 = '0;
        end
    end

    // ---------------- line store ----------------
    assign w_accept = i_valid && o_ready;
    assign w_raddr  = (r_state == ST_CRD) ? {r_out_ring, r_out_col} : {r_ring, r_c};

    mlt_linestore #(.AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && !i_mode && !r_in_done),
        .i_waddr ({r_in_ring, r_in_col}),
        .i_wdata (i_pixel),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- divider ----------------
    assign w_div_start = (r_state == ST_DIVS);

    mlt_div #(.DW(SUM_W), .VW(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // An empty window (possible only after a size change) has mean zero.
    // pixel > mean - c is the same as pixel + c > mean.
    assign w_mean = (r_cnt == '0) ? '0 : CMP_W'(w_quo);
    assign w_lhs  = CMP_W'(r_pix) + CMP_W'(r_c_offset);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state    = r_state;
        n_in_row   = r_in_row;
        n_in_ring  = r_in_ring;
        n_in_col   = r_in_col;
        n_in_done  = r_in_done;
        n_out_row  = r_out_row;
        n_out_ring = r_out_ring;
        n_out_col  = r_out_col;
        n_n        = r_n;
        n_have     = r_have;
        n_ovalid   = r_ovalid;
        n_oobj     = r_oobj;
        n_olast    = r_olast;
        n_ofd      = r_ofd;
        n_r        = r_r;
        n_r1       = r_r1;
        n_ring     = r_ring;
        n_c        = r_c;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_empty    = r_empty;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_pix      = r_pix;
        n_obj      = r_obj;
        n_fd       = r_fd;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!i_mode && !r_in_done) begin
                        if (CXW'(r_in_col) + 1'b1 >= w_w) begin
                            if (RXW'(r_in_row) + 1'b1 >= w_hgt) begin
                                n_in_done = 1'b1;
                            end else begin
                                n_in_col  = '0;
                                n_in_row  = r_in_row + 1'b1;
                                n_in_ring = (32'(r_in_ring) == RING - 1) ? '0
                                            : r_in_ring + 1'b1;
                            end
                        end else begin
                            n_in_col = r_in_col + 1'b1;
                        end
                    end
                    n_n     = '0;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (!r_have || !r_ovalid || i_ready) begin
                    if (r_have) begin
                        n_ovalid = 1'b1;
                        n_oobj   = r_obj;
                        n_olast  = !w_avail;
                        n_ofd    = r_fd;
                        n_have   = 1'b0;
                    end
                    if (w_avail) begin
                        n_r     = ROW_W'(w_r0x);
                        n_r1    = ROW_W'(w_r1x);
                        n_ring  = RW'(w_ring0);
                        n_c     = CW'(w_c0x);
                        n_c0    = CW'(w_c0x);
                        n_c1    = CW'(w_c1x);
                        n_empty = (w_r0x > w_r1x) || (w_c0x > w_c1x);
                        n_sum   = '0;
                        n_cnt   = '0;
                        n_state = ST_CRD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CRD: begin
                n_state = ST_CACC;
            end
            ST_CACC: begin
                n_pix   = w_rdata;
                n_state = r_empty ? ST_DIVS : ST_RD;
            end
            ST_RD: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_sum   = r_sum + SUM_W'(w_rdata);
                n_cnt   = r_cnt + 1'b1;
                n_state = ST_RD;
                if (r_c == r_c1) begin
                    n_c = r_c0;
                    if (r_r == r_r1) begin
                        n_state = ST_DIVS;
                    end else begin
                        n_r    = r_r + 1'b1;
                        n_ring = (32'(r_ring) == RING - 1) ? '0 : r_ring + 1'b1;
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            ST_DIVS: begin
                n_state = ST_DIVW;
            end
            ST_DIVW: begin
                if (w_div_done) begin
                    n_obj = (w_lhs > w_mean);
                    n_fd  = 1'b0;
                    if (CXW'(r_out_col) + 1'b1 >= w_w) begin
                        n_out_col = '0;
                        if (RXW'(r_out_row) + 1'b1 >= w_hgt) begin
                            // Final pixel: every position restarts for the next frame.
                            n_fd       = 1'b1;
                            n_out_row  = '0;
                            n_out_ring = '0;
                            n_in_row   = '0;
                            n_in_ring  = '0;
                            n_in_col   = '0;
                            n_in_done  = 1'b0;
                        end else begin
                            n_out_row  = r_out_row + 1'b1;
                            n_out_ring = (32'(r_out_ring) == RING - 1) ? '0
                                         : r_out_ring + 1'b1;
                        end
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                    n_n     = r_n + 1'b1;
                    n_have  = 1'b1;
                    n_state = ST_NEXT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_row   <= '0;
            r_in_ring  <= '0;
            r_in_col   <= '0;
            r_in_done  <= 1'b0;
            r_out_row  <= '0;
            r_out_ring <= '0;
            r_out_col  <= '0;
            r_n        <= '0;
            r_have     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_row   <= n_in_row;
            r_in_ring  <= n_in_ring;
            r_in_col   <= n_in_col;
            r_in_done  <= n_in_done;
            r_out_row  <= n_out_row;
            r_out_ring <= n_out_ring;
            r_out_col  <= n_out_col;
            r_n        <= n_n;
            r_have     <= n_have;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r     <= n_r;
        r_r1    <= n_r1;
        r_ring  <= n_ring;
        r_c     <= n_c;
        r_c0    <= n_c0;
        r_c1    <= n_c1;
        r_empty <= n_empty;
        r_sum   <= n_sum;
        r_cnt   <= n_cnt;
        r_pix   <= n_pix;
        r_obj   <= n_obj;
        r_fd    <= n_fd;
        r_oobj  <= n_oobj;
        r_olast <= n_olast;
        r_ofd   <= n_ofd;
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_object_bit  = r_oobj;
    assign o_last_in_run = r_olast;
    assign o_frame_done  = r_ofd;

    // ---------------- assertions ----------------
    a_frame_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_last_in_run)
        else $error("frame_done word not marked as last of its run");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= mlt_pkg::NOUT_W'(mlt_pkg::MAX_OUT))
        else $error("more results than allowed for one input word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken again before the previous word was processed");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIVW))
        else $error("divider finished outside its wait state");

endmodule

### verif/mlt_checker.sv
`timescale 1ns / 100ps
// Checker for the adaptive mean threshold block: watches both channels and the
// register port, predicts every result word and compares. Depends on mlt_pkg.
module mlt_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         drain,
    input  logic [7:0]                   pixel,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         object_bit,
    input  logic                         last_in_run,
    input  logic                         frame_done,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [mlt_pkg::APB_AW-1:0]   paddr,
    input  logic [mlt_pkg::APB_DW-1:0]   pwdata,
    output int                           fail_count,
    output int                           pending,
    output logic                         frame_open
);

    localparam int HALF_CAP = 7;
    localparam int LINE_CAP = 1024;
    localparam int RING     = 2 * HALF_CAP + 1;

    typedef struct packed {
        logic object_bit;
        logic last_in_run;
        logic frame_done;
    } t_result;

    t_result                               thresholds_due[$];
    logic [mlt_pkg::PIX_W-1:0]             rows_kept [RING * LINE_CAP];
    int unsigned                           in_r, in_c, out_r, out_c;
    logic                                  frame_in;
    logic [mlt_pkg::OFFSET_W-1:0]          offset_q;
    logic [mlt_pkg::HALF_W-1:0]            half_q;
    logic [mlt_pkg::FWIDTH_W-1:0]          width_q;
    logic [mlt_pkg::FHEIGHT_W-1:0]         height_q;

    initial fail_count = 0;
    assign pending    = thresholds_due.size();
    assign frame_open = frame_in || in_r != 0 || in_c != 0 || out_r != 0 || out_c != 0;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t: mismatch: %s", $realtime, what);
    endtask

    function automatic int unsigned kept_at(int unsigned r, int unsigned c);
        return rows_kept[(r % RING) * LINE_CAP + (c % LINE_CAP)];
    endfunction

    // Mean of the clipped window around the next output pixel, then the compare.
    function automatic logic pixel_is_object(int unsigned w, int unsigned hg, int unsigned h);
        int unsigned r0, r1, c0, c1, sum, cells;
        int          mean;
        r0 = out_r >= h ? out_r - h : 0;
        r1 = (out_r + h > hg - 1) ? hg - 1 : out_r + h;
        c0 = out_c >= h ? out_c - h : 0;
        c1 = (out_c + h > w - 1) ? w - 1 : out_c + h;
        sum = 0;
        cells = 0;
        for (int unsigned r = r0; r <= r1; r++) begin
            for (int unsigned c = c0; c <= c1; c++) begin
                sum += kept_at(r, c);
                cells++;
            end
        end
        mean = cells != 0 ? int'(sum / cells) : 0;
        return int'(kept_at(out_r, out_c)) > mean - int'(offset_q);
    endfunction

    function automatic logic window_complete(int unsigned w, int unsigned hg, int unsigned h);
        int unsigned nr, nc;
        if (frame_in) return 1'b1;
        nr = (out_r + h > hg - 1) ? hg - 1 : out_r + h;
        nc = (out_c + h > w - 1) ? w - 1 : out_c + h;
        return nr < in_r || (nr == in_r && nc < in_c);
    endfunction

    task automatic predict_results(input logic is_drain, input logic [7:0] pix);
        int unsigned w, hg, h;
        int          n;
        t_result     word;
        w  = width_q == 0 ? 1 : (width_q > LINE_CAP ? LINE_CAP : width_q);
        hg = height_q == 0 ? 1
             : (height_q > mlt_pkg::MAX_HEIGHT ? mlt_pkg::MAX_HEIGHT : height_q);
        h  = half_q > HALF_CAP ? HALF_CAP : half_q;
        n  = 0;
        if (!is_drain && !frame_in) begin
            rows_kept[(in_r % RING) * LINE_CAP + (in_c % LINE_CAP)] = pix;
            if (in_c + 1 >= w) begin
                if (in_r + 1 >= hg) begin
                    frame_in = 1'b1;
                end else begin
                    in_c = 0;
                    in_r++;
                end
            end else begin
                in_c++;
            end
        end
        while (n < mlt_pkg::MAX_OUT && window_complete(w, hg, h)) begin
            word.object_bit  = pixel_is_object(w, hg, h);
            word.last_in_run = 1'b0;
            word.frame_done  = 1'b0;
            if (out_c + 1 >= w) begin
                out_c = 0;
                if (out_r + 1 >= hg) word.frame_done = 1'b1;
                else out_r++;
            end else begin
                out_c++;
            end
            thresholds_due.insert(thresholds_due.size(), word);
            n++;
            if (word.frame_done) begin
                in_r = 0;
                in_c = 0;
                out_r = 0;
                out_c = 0;
                frame_in = 1'b0;
            end
        end
        if (n > 0) thresholds_due[thresholds_due.size() - 1].last_in_run = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            thresholds_due.delete();
            in_r = 0;
            in_c = 0;
            out_r = 0;
            out_c = 0;
            frame_in = 1'b0;
            offset_q = mlt_pkg::RST_C_OFFSET;
            half_q   = mlt_pkg::RST_WINDOW_HALF;
            width_q  = mlt_pkg::RST_FRAME_WIDTH;
            height_q = mlt_pkg::RST_FRAME_HEIGHT;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    mlt_pkg::REG_C_OFFSET:     offset_q = pwdata[mlt_pkg::OFFSET_W-1:0];
                    mlt_pkg::REG_WINDOW_HALF:  half_q   = pwdata[mlt_pkg::HALF_W-1:0];
                    mlt_pkg::REG_FRAME_WIDTH:  width_q  = pwdata[mlt_pkg::FWIDTH_W-1:0];
                    mlt_pkg::REG_FRAME_HEIGHT: height_q = pwdata[mlt_pkg::FHEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) predict_results(drain, pixel);
            if (out_valid && out_ready) begin
                got = '{object_bit, last_in_run, frame_done};
                if (thresholds_due.size() == 0) begin
                    report_mismatch("result word with none expected");
                end else begin
                    want = thresholds_due.pop_front();
                    if (got.object_bit !== want.object_bit)
                        report_mismatch($sformatf("object_bit %b, expected %b",
                            got.object_bit, want.object_bit));
                    if (got.last_in_run !== want.last_in_run)
                        report_mismatch($sformatf("last_in_run %b, expected %b",
                            got.last_in_run, want.last_in_run));
                    if (got.frame_done !== want.frame_done)
                        report_mismatch($sformatf("frame_done %b, expected %b",
                            got.frame_done, want.frame_done));
                end
            end
        end
    end
endmodule

### verif/mean_local_threshold_tb.sv
`timescale 1ns / 100ps
// Top of the threshold testbench: clock, reset, register writes and pixel
// stimulus. Depends on mlt_pkg, mean_local_threshold and mlt_checker.
module mean_local_threshold_tb;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;
    localparam int   CYCLE_LIMIT = 6000000;
    localparam int   SETTLE = 60;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        i_mode = MODE_PIXEL;
    logic [7:0]                  i_pixel = '0;
    logic                        i_ready = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [mlt_pkg::APB_AW-1:0]  paddr = '0;
    logic [mlt_pkg::APB_DW-1:0]  pwdata = '0;
    logic                        o_ready, o_valid, o_object_bit, o_last_in_run, o_frame_done;
    logic                        pready;
    logic [mlt_pkg::APB_DW-1:0]  prdata;
    int                          fail_count, pending;
    logic                        frame_open;
    logic                        calm = 1'b0;
    int                          cycles = 0;
    int                          pixels_sent = 0;

    mean_local_threshold dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_pixel(i_pixel), .o_valid(o_valid), .i_ready(i_ready),
        .o_object_bit(o_object_bit), .o_last_in_run(o_last_in_run),
        .o_frame_done(o_frame_done), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mlt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(i_valid), .in_ready(o_ready),
        .drain(i_mode == MODE_DRAIN), .pixel(i_pixel), .out_valid(o_valid),
        .out_ready(i_ready), .object_bit(o_object_bit), .last_in_run(o_last_in_run),
        .frame_done(o_frame_done), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
        .pending(pending), .frame_open(frame_open)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) i_ready <= calm || ($urandom_range(99) >= 8);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_results;
        while (pending != 0) @(posedge i_clk);
    endtask

    // Idle point for register writes: every result in, then a short settle
    // for words that released nothing.
    task automatic go_idle;
        @(negedge i_clk);
        i_valid = 1'b0;
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_frame(input int unsigned c, input int unsigned h,
                             input int unsigned w, input int unsigned hg);
        go_idle();
        write_reg(mlt_pkg::REG_C_OFFSET, c);
        write_reg(mlt_pkg::REG_WINDOW_HALF, h);
        write_reg(mlt_pkg::REG_FRAME_WIDTH, w);
        write_reg(mlt_pkg::REG_FRAME_HEIGHT, hg);
    endtask

    // Returns at the falling edge after the accept, once the checker has
    // taken the word into its prediction.
    task automatic send_word(input logic mode, input logic [7:0] pix);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 8) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_mode = mode;
        i_pixel = pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (mode == MODE_PIXEL) pixels_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Drain words, mixed with surplus pixel words, until the predicted frame has closed.
    task automatic close_frame;
        while (frame_open) begin
            if ($urandom_range(3) == 0) send_word(MODE_PIXEL, 8'($urandom));
            else send_word(MODE_DRAIN, 8'($urandom));
        end
    endtask

    task automatic random_frame(input int unsigned w, input int unsigned hg,
                                input logic pause_once);
        for (int unsigned i = 0; i < w * hg; i++) begin
            if ($urandom_range(9) == 0) send_word(MODE_DRAIN, 8'($urandom));
            if (pause_once && i == (w * hg) / 2) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                wait_results();
            end
            send_word(MODE_PIXEL, 8'($urandom));
        end
        close_frame();
    endtask

    initial begin
        int unsigned w, hg;
        logic        first_frame;
        first_frame = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Window wider than the frame: ten results wait at frame end, so the
        // cap splits them, and the extra pixel word is dropped.
        set_frame(0, 7, 5, 2);
        for (int i = 0; i < 10; i++) send_word(MODE_PIXEL, i[0] ? 8'hFF : 8'h00);
        send_word(MODE_PIXEL, 8'h80);
        close_frame();

        // Single-cell window with the largest offset: everything is object.
        set_frame(255, 0, 2, 2);
        send_word(MODE_PIXEL, 8'h00);
        send_word(MODE_DRAIN, 8'hFF);
        send_word(MODE_PIXEL, 8'hFF);
        send_word(MODE_PIXEL, 8'h01);
        send_word(MODE_PIXEL, 8'hFE);
        close_frame();

        // One pixel frame.
        set_frame(0, 3, 1, 1);
        send_word(MODE_PIXEL, 8'h7F);
        close_frame();

        // Two long rows, no receiver stalls or sender gaps.
        calm = 1'b1;
        set_frame(10, 2, 40, 2);
        for (int i = 0; i < 80; i++) send_word(MODE_PIXEL, 8'($urandom));
        close_frame();
        calm = 1'b0;

        while (pixels_sent < 280) begin
            w  = $urandom_range(7) == 0 ? $urandom_range(40, 11) : $urandom_range(10, 1);
            hg = $urandom_range(6, 1);
            set_frame($urandom_range(3) == 0 ? ($urandom_range(1) ? 255 : 0)
                                             : $urandom_range(255),
                      $urandom_range(7), w, hg);
            random_frame(w, hg, first_frame);
            first_frame = 1'b0;
        end

        // Tallest frame, left unfinished at the end of the run.
        set_frame(5, 7, 1, 4096);
        for (int i = 0; i < 40; i++) send_word(MODE_PIXEL, 8'($urandom));
        send_word(MODE_DRAIN, 8'h00);

        go_idle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### filelist.f
sv/mlt_pkg.sv
sv/mlt_div.sv
sv/mlt_linestore.sv
sv/mean_local_threshold.sv
verif/mlt_checker.sv
verif/mean_local_threshold_tb.sv
